// ===== src/lobm_pkg.sv =====
// Package with shared types, codes and default sizes of the order book matcher.
`timescale 1ns / 1ps
package lobm_pkg;

  localparam int NUM_SECURITIES_DEF = 8;
  localparam int BOOK_DEPTH_DEF = 32;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic SIDE_BID = 1'b0;

  localparam logic [1:0] ST_RESTING = 2'd0;
  localparam logic [1:0] ST_PARTIAL = 2'd1;
  localparam logic [1:0] ST_FILLED = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  typedef struct packed {
    logic [2:0]  security;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [15:0] client;
  } order_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  trade_security;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic [15:0] buyer;
    logic [15:0] seller;
    logic [31:0] remaining;
    logic [1:0]  order_status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [15:0] client;
    logic [31:0] age;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_REJECT,
    OP_SCAN_CLEAR,
    OP_TRADE,
    OP_FINISH,
    OP_CLEAR_WR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic rd_en;
    logic rd_own;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic best_found;
    logic crossing;
    logic rem_zero;
    logic trades_full;
  } status_t;

endpackage

// ===== src/lobm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lobm_datapath.sv =====
// Datapath of the order book matcher: order registers, book memory, best-slot search and results.
`timescale 1ns / 1ps
module lobm_datapath #(
  parameter int NUM_SECURITIES = lobm_pkg::NUM_SECURITIES_DEF,
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  lobm_pkg::order_t                              order,
  input  lobm_pkg::cmd_t                                cmd,
  input  logic [$clog2(BOOK_DEPTH)-1:0]                 scan_idx,
  input  logic [$clog2(NUM_SECURITIES*2*BOOK_DEPTH)-1:0] clr_addr,
  output lobm_pkg::status_t                             status,
  output lobm_pkg::result_t                             result,
  output logic                                          result_valid
);

  localparam int NumSlots = NUM_SECURITIES * 2 * BOOK_DEPTH;
  localparam int SlotW = $clog2(NumSlots);
  localparam int IdxW = $clog2(BOOK_DEPTH);
  localparam int CntW = $clog2(BOOK_DEPTH + 1);
  localparam int EntryW = $bits(lobm_pkg::entry_t);

  logic [2:0]  sec;
  logic        side;
  logic [31:0] price;
  logic [31:0] rem;
  logic [15:0] client;
  logic        traded;
  logic        reject;
  logic [CntW-1:0] ntrades;
  logic [31:0] arrival_counter;

  logic            best_found;
  logic [IdxW-1:0] best_idx;
  logic [31:0]     best_price;
  logic [31:0]     best_qty;
  logic [15:0]     best_client;
  logic [31:0]     best_age;
  logic [31:0]     best_dist;
  logic            free_found;
  logic [IdxW-1:0] free_idx;

  logic            rd_en_d;
  logic            rd_own_d;
  logic [IdxW-1:0] rd_idx_d;

  logic                  we;
  logic [SlotW-1:0]      waddr;
  lobm_pkg::entry_t      wentry;
  logic [SlotW-1:0]      raddr;
  logic [EntryW-1:0]     rdata;
  lobm_pkg::entry_t      rentry;

  logic [31:0] fill_qty;
  logic [31:0] rdist;
  logic        better;
  logic [SlotW-1:0] opp_base;
  logic [SlotW-1:0] own_base;
  lobm_pkg::result_t res_next;

  assign rentry = lobm_pkg::entry_t'(rdata);
  assign fill_qty = (best_qty < rem) ? best_qty : rem;
  assign rdist = arrival_counter - rentry.age;
  assign better = (side == lobm_pkg::SIDE_BID) ? (rentry.price < best_price)
                                               : (rentry.price > best_price);
  assign opp_base = SlotW'((int'(sec) * 2 + int'(!side)) * BOOK_DEPTH);
  assign own_base = SlotW'((int'(sec) * 2 + int'(side)) * BOOK_DEPTH);
  assign raddr = (cmd.rd_own ? own_base : opp_base) + SlotW'(scan_idx);

  always_comb begin
    we = 1'b0;
    waddr = clr_addr;
    wentry = '0;
    case (cmd.op)
      lobm_pkg::OP_CLEAR_WR: begin
        we = 1'b1;
      end
      lobm_pkg::OP_TRADE: begin
        we = 1'b1;
        waddr = opp_base + SlotW'(best_idx);
        wentry.valid = (best_qty - fill_qty) != 32'd0;
        wentry.price = best_price;
        wentry.quantity = best_qty - fill_qty;
        wentry.client = best_client;
        wentry.age = best_age;
      end
      lobm_pkg::OP_FINISH: begin
        we = (rem != 32'd0) && free_found;
        waddr = own_base + SlotW'(free_idx);
        wentry.valid = 1'b1;
        wentry.price = price;
        wentry.quantity = rem;
        wentry.client = client;
        wentry.age = arrival_counter;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_next = '0;
    res_next.trade_security = sec;
    case (cmd.op)
      lobm_pkg::OP_REJECT: begin
        res_next.kind = lobm_pkg::KIND_SUMMARY;
        res_next.remaining = rem;
        res_next.order_status = (int'(sec) >= NUM_SECURITIES) ? lobm_pkg::ST_DROPPED
                                                              : lobm_pkg::ST_FILLED;
        res_next.last = 1'b1;
      end
      lobm_pkg::OP_TRADE: begin
        res_next.kind = lobm_pkg::KIND_TRADE;
        res_next.trade_price = best_price;
        res_next.trade_quantity = fill_qty;
        res_next.buyer = (side == lobm_pkg::SIDE_BID) ? client : best_client;
        res_next.seller = (side == lobm_pkg::SIDE_BID) ? best_client : client;
      end
      lobm_pkg::OP_FINISH: begin
        res_next.kind = lobm_pkg::KIND_SUMMARY;
        res_next.remaining = rem;
        if (rem == 32'd0) begin
          res_next.order_status = lobm_pkg::ST_FILLED;
        end else if (!free_found) begin
          res_next.order_status = lobm_pkg::ST_DROPPED;
        end else begin
          res_next.order_status = traded ? lobm_pkg::ST_PARTIAL : lobm_pkg::ST_RESTING;
        end
        res_next.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  lobm_ram #(
    .WIDTH(EntryW),
    .DEPTH(NumSlots)
  ) u_book (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(EntryW'(wentry)),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign status.reject = reject;
  assign status.best_found = best_found;
  assign status.crossing = (side == lobm_pkg::SIDE_BID) ? (price >= best_price)
                                                        : (price <= best_price);
  assign status.rem_zero = rem == 32'd0;
  assign status.trades_full = ntrades == CntW'(BOOK_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_counter <= '0;
      result_valid <= 1'b0;
      rd_en_d <= 1'b0;
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_en_d <= cmd.rd_en;
      rd_own_d <= cmd.rd_own;
      rd_idx_d <= scan_idx;

      if (rd_en_d) begin
        if (!rd_own_d) begin
          if (rentry.valid && (!best_found || better ||
              (rentry.price == best_price && rdist > best_dist))) begin
            best_found <= 1'b1;
            best_idx <= rd_idx_d;
            best_price <= rentry.price;
            best_qty <= rentry.quantity;
            best_client <= rentry.client;
            best_age <= rentry.age;
            best_dist <= rdist;
          end
        end else if (!rentry.valid && !free_found) begin
          free_found <= 1'b1;
          free_idx <= rd_idx_d;
        end
      end

      case (cmd.op)
        lobm_pkg::OP_LOAD: begin
          sec <= order.security;
          side <= order.side;
          price <= order.limit_price;
          rem <= order.quantity;
          client <= order.client;
          traded <= 1'b0;
          ntrades <= '0;
          reject <= (int'(order.security) >= NUM_SECURITIES) ||
                    (order.quantity == 32'd0);
        end
        lobm_pkg::OP_REJECT: begin
          result <= res_next;
          result_valid <= 1'b1;
        end
        lobm_pkg::OP_SCAN_CLEAR: begin
          best_found <= 1'b0;
          free_found <= 1'b0;
        end
        lobm_pkg::OP_TRADE: begin
          result <= res_next;
          result_valid <= 1'b1;
          rem <= rem - fill_qty;
          traded <= 1'b1;
          ntrades <= ntrades + CntW'(1);
          best_found <= 1'b0;
        end
        lobm_pkg::OP_FINISH: begin
          result <= res_next;
          result_valid <= 1'b1;
          arrival_counter <= arrival_counter + 32'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/lobm_ctrl.sv =====
// Controller state machine of the order book matcher.
`timescale 1ns / 1ps
module lobm_ctrl #(
  parameter int NUM_SECURITIES = lobm_pkg::NUM_SECURITIES_DEF,
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  lobm_pkg::status_t                             status,
  output lobm_pkg::cmd_t                                cmd,
  output logic [$clog2(BOOK_DEPTH)-1:0]                 scan_idx,
  output logic [$clog2(NUM_SECURITIES*2*BOOK_DEPTH)-1:0] clr_addr,
  output logic                                          busy
);

  localparam int NumSlots = NUM_SECURITIES * 2 * BOOK_DEPTH;
  localparam int SlotW = $clog2(NumSlots);
  localparam int IdxW = $clog2(BOOK_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SCAN_LAST,
    S_DECIDE,
    S_TRADE,
    S_OWN,
    S_OWN_LAST,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op = lobm_pkg::OP_NONE;
    cmd.rd_en = 1'b0;
    cmd.rd_own = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = lobm_pkg::OP_CLEAR_WR;
        if (clr_addr == SlotW'(NumSlots - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = lobm_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.reject) begin
          cmd.op = lobm_pkg::OP_REJECT;
          state_next = S_IDLE;
        end else begin
          cmd.op = lobm_pkg::OP_SCAN_CLEAR;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (scan_idx == IdxW'(BOOK_DEPTH - 1)) begin
          state_next = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.rem_zero) begin
          state_next = S_FINISH;
        end else if (status.best_found && status.crossing && !status.trades_full) begin
          state_next = S_TRADE;
        end else begin
          cmd.op = lobm_pkg::OP_SCAN_CLEAR;
          state_next = S_OWN;
        end
      end
      S_TRADE: begin
        cmd.op = lobm_pkg::OP_TRADE;
        state_next = S_SCAN;
      end
      S_OWN: begin
        cmd.rd_en = 1'b1;
        cmd.rd_own = 1'b1;
        if (scan_idx == IdxW'(BOOK_DEPTH - 1)) begin
          state_next = S_OWN_LAST;
        end
      end
      S_OWN_LAST: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.op = lobm_pkg::OP_FINISH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      scan_idx <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + SlotW'(1);
      end
      if (state == S_SCAN || state == S_OWN) begin
        scan_idx <= (scan_idx == IdxW'(BOOK_DEPTH - 1)) ? '0 : scan_idx + IdxW'(1);
      end else begin
        scan_idx <= '0;
      end
    end
  end

endmodule

// ===== src/limit_order_book_matcher_top.sv =====
// Top level of the price-time priority limit order book matcher.
// An accepted order keeps busy high through a scan of the opposite side, a further scan per trade and
// a scan of its own side when a remainder searches for a free slot, each reading the book memory
// at one slot per cycle; a rejected order keeps busy high for 1 cycle.
// Each result is shown for one cycle on result with result_valid; the receiver cannot stall.
// After reset busy is high while the book is cleared.
`timescale 1ns / 1ps
module limit_order_book_matcher_top #(
  parameter int NUM_SECURITIES = lobm_pkg::NUM_SECURITIES_DEF,
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lobm_pkg::order_t  order,
  output lobm_pkg::result_t result,
  output logic              result_valid
);

  localparam int SlotW = $clog2(NUM_SECURITIES * 2 * BOOK_DEPTH);
  localparam int IdxW = $clog2(BOOK_DEPTH);

  lobm_pkg::cmd_t    cmd;
  lobm_pkg::status_t status;
  logic [IdxW-1:0]   scan_idx;
  logic [SlotW-1:0]  clr_addr;

  lobm_ctrl #(
    .NUM_SECURITIES(NUM_SECURITIES),
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .status  (status),
    .cmd     (cmd),
    .scan_idx(scan_idx),
    .clr_addr(clr_addr),
    .busy    (busy)
  );

  lobm_datapath #(
    .NUM_SECURITIES(NUM_SECURITIES),
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .order       (order),
    .cmd         (cmd),
    .scan_idx    (scan_idx),
    .clr_addr    (clr_addr),
    .status      (status),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule

// ===== verif/limit_order_book_matcher_checker.sv =====
// Checker that predicts and compares the results of the order book matcher.
`timescale 1ns / 1ps
module limit_order_book_matcher_checker #(
  parameter int NUM_SECURITIES = lobm_pkg::NUM_SECURITIES_DEF,
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  lobm_pkg::order_t  order,
  input  lobm_pkg::result_t result,
  input  logic              result_valid,
  output int                fail_count,
  output int                pending
);

  localparam int NUM_SLOTS = NUM_SECURITIES * 2 * BOOK_DEPTH;

  logic        book_valid [NUM_SLOTS];
  logic [31:0] book_price [NUM_SLOTS];
  logic [31:0] book_qty [NUM_SLOTS];
  logic [15:0] book_client [NUM_SLOTS];
  logic [31:0] book_age [NUM_SLOTS];
  logic [31:0] arrivals;
  lobm_pkg::result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic void queue_result(lobm_pkg::result_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic lobm_pkg::result_t summary(logic [2:0] sec, logic [31:0] rem,
                                                logic [1:0] st);
    lobm_pkg::result_t r;
    r = '0;
    r.kind = lobm_pkg::KIND_SUMMARY;
    r.trade_security = sec;
    r.remaining = rem;
    r.order_status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int best_resting(int base, logic want_low);
    int best;
    logic [31:0] best_dist;
    logic [31:0] age_gap;
    logic better;
    best = -1;
    best_dist = '0;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (book_valid[base + i]) begin
        age_gap = arrivals - book_age[base + i];
        if (best < 0) begin
          best = base + i;
          best_dist = age_gap;
        end else begin
          better = want_low ? (book_price[base + i] < book_price[best])
                            : (book_price[base + i] > book_price[best]);
          if (better || (book_price[base + i] == book_price[best] && age_gap > best_dist)) begin
            best = base + i;
            best_dist = age_gap;
          end
        end
      end
    end
    return best;
  endfunction

  task automatic predict_order(lobm_pkg::order_t o);
    logic [31:0] rem;
    int own;
    int opp;
    int s;
    int n;
    int free_slot;
    logic traded;
    logic crosses;
    logic [31:0] q;
    logic [1:0] st;
    lobm_pkg::result_t r;
    rem = o.quantity;
    n = 0;
    traded = 1'b0;
    if (int'(o.security) >= NUM_SECURITIES) begin
      queue_result(summary(o.security, rem, lobm_pkg::ST_DROPPED));
      return;
    end
    if (rem == 0) begin
      queue_result(summary(o.security, '0, lobm_pkg::ST_FILLED));
      return;
    end
    own = (int'(o.security) * 2 + int'(o.side)) * BOOK_DEPTH;
    opp = (int'(o.security) * 2 + int'(!o.side)) * BOOK_DEPTH;
    while (rem > 0 && n < BOOK_DEPTH) begin
      s = best_resting(opp, o.side == lobm_pkg::SIDE_BID);
      if (s < 0) break;
      crosses = (o.side == lobm_pkg::SIDE_BID) ? (o.limit_price >= book_price[s])
                                               : (o.limit_price <= book_price[s]);
      if (!crosses) break;
      q = (book_qty[s] < rem) ? book_qty[s] : rem;
      r = '0;
      r.kind = lobm_pkg::KIND_TRADE;
      r.trade_security = o.security;
      r.trade_price = book_price[s];
      r.trade_quantity = q;
      r.buyer = (o.side == lobm_pkg::SIDE_BID) ? o.client : book_client[s];
      r.seller = (o.side == lobm_pkg::SIDE_BID) ? book_client[s] : o.client;
      queue_result(r);
      n++;
      traded = 1'b1;
      rem -= q;
      book_qty[s] -= q;
      if (book_qty[s] == 0) book_valid[s] = 1'b0;
    end
    if (rem == 0) begin
      st = lobm_pkg::ST_FILLED;
    end else begin
      free_slot = -1;
      for (int i = 0; i < BOOK_DEPTH; i++) begin
        if (free_slot < 0 && !book_valid[own + i]) free_slot = own + i;
      end
      if (free_slot < 0) begin
        st = lobm_pkg::ST_DROPPED;
      end else begin
        book_valid[free_slot] = 1'b1;
        book_price[free_slot] = o.limit_price;
        book_qty[free_slot] = rem;
        book_client[free_slot] = o.client;
        book_age[free_slot] = arrivals;
        st = traded ? lobm_pkg::ST_PARTIAL : lobm_pkg::ST_RESTING;
      end
    end
    arrivals++;
    queue_result(summary(o.security, rem, st));
  endtask

  always @(posedge clk) begin
    lobm_pkg::result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) book_valid[i] <= 1'b0;
      arrivals <= '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            if (fail_count < 10) $display("Mismatch: expected %p, actual %p", want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_order(order);
    end
  end
endmodule

// ===== verif/limit_order_book_matcher_top_test.sv =====
// Testbench top that drives orders into the order book matcher and reports the verdict.
`timescale 1ns / 1ps
module limit_order_book_matcher_top_test;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  lobm_pkg::order_t  order = '0;
  lobm_pkg::result_t result;
  logic    result_valid;
  int      fail_count;
  int      pending;
  int      cycles = 0;
  int      idle_pct = 0;

  always #10 clk = ~clk;

  limit_order_book_matcher_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .order(order), .result(result), .result_valid(result_valid)
  );

  limit_order_book_matcher_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .order(order),
    .result(result), .result_valid(result_valid),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("limit_order_book_matcher_top test failed");
      $finish;
    end
  end

  // Holds one order on the inputs until the matcher takes it.
  task automatic send_order(logic [2:0] sec, logic side, logic [31:0] price,
                            logic [31:0] qty, logic [15:0] client);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    order <= '{security: sec, side: side, limit_price: price, quantity: qty, client: client};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic random_order(bit wide);
    logic [31:0] price;
    logic [31:0] qty;
    if (wide) begin
      price = $urandom;
      qty = $urandom;
    end else begin
      price = 32'd100 + $urandom_range(8);
      qty = $urandom_range(1, 40);
    end
    if ($urandom_range(49) == 0) qty = '0;
    send_order(3'($urandom_range(7)), 1'($urandom_range(1)), price, qty, 16'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_order(3'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_order(3'd0, 1'b0, 32'hFFFF_FFFF, 32'd5, 16'h0000);
    send_order(3'd0, 1'b0, 32'd0, 32'd1, 16'h1234);
    send_order(3'd0, 1'b1, 32'd0, 32'd3, 16'h5678);
    send_order(3'd7, 1'b0, 32'd50, 32'd0, 16'hAAAA);
    send_order(3'd7, 1'b1, 32'd60, 32'd10, 16'h5555);
    send_order(3'd7, 1'b1, 32'd60, 32'd10, 16'h0001);
    send_order(3'd7, 1'b1, 32'd55, 32'd4, 16'h0002);
    send_order(3'd7, 1'b0, 32'd60, 32'd30, 16'h0003);
    send_order(3'd7, 1'b0, 32'd59, 32'd3, 16'h0004);
    // Fill one side of a book completely, then overflow it.
    for (int i = 0; i < lobm_pkg::BOOK_DEPTH_DEF + 2; i++) begin
      send_order(3'd3, 1'b0, 32'd10 + 32'(i), 32'd2, 16'(i));
    end
    send_order(3'd3, 1'b1, 32'd0, 32'hFFFF_FFFF, 16'hBEEF);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 63 : (ph == 3) ? 14 : 0;
      for (int k = 0; k < 95; k++) random_order($urandom_range(9) == 0);
    end
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("limit_order_book_matcher_top test passed");
    end else begin
      $display("limit_order_book_matcher_top test failed");
    end
    $finish;
  end
endmodule
